/* src/css_pkg.sv */
// css_pkg: shared sizes, action and status codes, and the cell control bundle
// for the cursor sequence store; used by css_cell and cursor_sequence_store_core
package css_pkg;

    localparam int DEPTH     = 32;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // fixed field widths of the ports
    localparam int ACT_W     = 4;
    localparam int PORT_W    = 32;
    localparam int RIDX_W    = 5;
    localparam int STAT_W    = 2;
    localparam int OUT_CNT_W = 6;

    typedef enum logic [ACT_W-1:0] {
        ACT_START      = 4'd0,
        ACT_ADVANCE    = 4'd1,
        ACT_END        = 4'd2,
        ACT_INSERT     = 4'd3,
        ACT_ATTACH     = 4'd4,
        ACT_REMOVE     = 4'd5,
        ACT_RM_FRONT   = 4'd6,
        ACT_PUSH_FRONT = 4'd7,
        ACT_PUSH_END   = 4'd8,
        ACT_READ       = 4'd9
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        GAP_NONE  = 2'd0,
        GAP_OPEN  = 2'd1,
        GAP_CLOSE = 2'd2
    } t_gap;

    // broadcast to every cell of the row
    typedef struct packed {
        logic                 en;
        t_gap                 op;
        logic [IDX_W-1:0]     pos;
        logic [WORD_BITS-1:0] word;
    } t_cell_ctrl;

endpackage

/* src/cursor_sequence_store_core.sv */
// cursor_sequence_store_core: top level of the cursor sequence store, a row of
// css_cell slots with count, cursor and result registers; depends on css_pkg, css_cell
//
// Bounded ordered list of up to DEPTH words with a cursor. Each input beat carries
// one action (start, advance, end, insert, attach, remove current, remove front,
// push front, push end, read) and yields exactly one result beat with status,
// read data, current word, count and cursor. One action is accepted per clock while
// the input side is not stalled: the word row shifts by one place on the accepting
// edge, each cell taking its neighbor's word. That edge also updates the count and
// cursor and loads the pending status and read data; when the output register is
// free, the pending result moves into it and the word under the cursor is sampled.
// A pending register in front of the output register lets the next beat in while a
// result waits, so the input side stalls only when both hold a result and the output
// beat is not being taken. The word row has no reset and needs no clearing pass:
// only positions below the count are ever read.
module cursor_sequence_store_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [css_pkg::ACT_W-1:0]     i_action,
    input  logic [css_pkg::PORT_W-1:0]    i_word_in,
    input  logic [css_pkg::RIDX_W-1:0]    i_read_index,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [css_pkg::STAT_W-1:0]    o_status,
    output logic [css_pkg::PORT_W-1:0]    o_read_word,
    output logic                          o_has_current,
    output logic [css_pkg::PORT_W-1:0]    o_current_word,
    output logic [css_pkg::OUT_CNT_W-1:0] o_word_count,
    output logic [css_pkg::OUT_CNT_W-1:0] o_cursor_pos
);

    // list state
    logic [css_pkg::CNT_W-1:0]     r_count;
    logic [css_pkg::CNT_W-1:0]     r_cursor;
    logic [css_pkg::CNT_W-1:0]     n_count;
    logic [css_pkg::CNT_W-1:0]     n_cursor;

    // pending result: status and read data of the last accepted beat
    logic                          r_pend_valid;
    css_pkg::t_status              r_pend_status;
    logic [css_pkg::PORT_W-1:0]    r_pend_rword;
    css_pkg::t_status              n_status;
    logic [css_pkg::PORT_W-1:0]    n_rword;

    // output register
    logic                          r_out_valid;
    css_pkg::t_status              r_out_status;
    logic [css_pkg::PORT_W-1:0]    r_out_rword;
    logic                          r_out_has_cur;
    logic [css_pkg::PORT_W-1:0]    r_out_cur_word;
    logic [css_pkg::OUT_CNT_W-1:0] r_out_count;
    logic [css_pkg::OUT_CNT_W-1:0] r_out_cursor;

    // cell row
    logic [css_pkg::WORD_BITS-1:0] w_cells [css_pkg::DEPTH];
    css_pkg::t_cell_ctrl           w_ctrl;

    logic                          w_accept;
    logic                          w_pend_move;
    logic                          w_full;
    logic                          w_empty;
    logic                          w_has_cur;
    logic [css_pkg::CNT_W-1:0]     w_count_inc;
    logic [css_pkg::CNT_W-1:0]     w_count_dec;
    logic [css_pkg::CNT_W-1:0]     w_attach_pos;
    logic [css_pkg::IDX_W-1:0]     w_ridx_sel;
    logic                          w_ridx_ok;
    logic [css_pkg::IDX_W-1:0]     w_cur_sel;
    css_pkg::t_gap                 w_gap;
    logic [css_pkg::CNT_W-1:0]     w_gap_pos;

    // pending result drains into the output register whenever that is free
    assign w_pend_move = r_pend_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_pend_valid || w_pend_move;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_full      = (r_count == css_pkg::CNT_W'(css_pkg::DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_has_cur   = (r_cursor < r_count);
    assign w_count_inc = r_count + css_pkg::CNT_W'(1);
    assign w_count_dec = r_count - css_pkg::CNT_W'(1);
    // attach lands after the current word, or at the end when there is none
    assign w_attach_pos = w_has_cur ? (r_cursor + css_pkg::CNT_W'(1)) : r_cursor;

    assign w_ridx_sel = css_pkg::IDX_W'(i_read_index);
    assign w_ridx_ok  = (32'(i_read_index) < 32'(r_count))
                     && (32'(i_read_index) < css_pkg::DEPTH);

    // action decode
    always_comb begin
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_status  = css_pkg::ST_OK;
        n_rword   = '0;
        w_gap     = css_pkg::GAP_NONE;
        w_gap_pos = r_cursor;
        unique case (css_pkg::t_action'(i_action))
            css_pkg::ACT_START: begin
                n_cursor = '0;
            end
            css_pkg::ACT_ADVANCE: begin
                if (w_has_cur) begin
                    n_cursor = r_cursor + css_pkg::CNT_W'(1);
                end else begin
                    n_status = css_pkg::ST_RANGE;
                end
            end
            css_pkg::ACT_END: begin
                n_cursor = r_count;
            end
            css_pkg::ACT_INSERT: begin
                if (w_full) begin
                    n_status = css_pkg::ST_FULL;
                end else begin
                    w_gap     = css_pkg::GAP_OPEN;
                    w_gap_pos = r_cursor;
                    n_count   = w_count_inc;
                end
            end
            css_pkg::ACT_ATTACH: begin
                if (w_full) begin
                    n_status = css_pkg::ST_FULL;
                end else begin
                    w_gap     = css_pkg::GAP_OPEN;
                    w_gap_pos = w_attach_pos;
                    n_cursor  = w_attach_pos;
                    n_count   = w_count_inc;
                end
            end
            css_pkg::ACT_REMOVE: begin
                if (w_empty) begin
                    n_status = css_pkg::ST_EMPTY;
                end else if (!w_has_cur) begin
                    // no current word: drop the last one, cursor follows the count
                    n_count  = w_count_dec;
                    n_cursor = w_count_dec;
                end else begin
                    w_gap     = css_pkg::GAP_CLOSE;
                    w_gap_pos = r_cursor;
                    n_count   = w_count_dec;
                end
            end
            css_pkg::ACT_RM_FRONT: begin
                if (w_empty) begin
                    n_status = css_pkg::ST_EMPTY;
                end else begin
                    w_gap     = css_pkg::GAP_CLOSE;
                    w_gap_pos = '0;
                    n_cursor  = '0;
                    n_count   = w_count_dec;
                end
            end
            css_pkg::ACT_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = css_pkg::ST_FULL;
                end else begin
                    w_gap     = css_pkg::GAP_OPEN;
                    w_gap_pos = '0;
                    n_cursor  = '0;
                    n_count   = w_count_inc;
                end
            end
            css_pkg::ACT_PUSH_END: begin
                if (w_full) begin
                    n_status = css_pkg::ST_FULL;
                end else begin
                    w_gap     = css_pkg::GAP_OPEN;
                    w_gap_pos = r_count;
                    n_cursor  = r_count;
                    n_count   = w_count_inc;
                end
            end
            css_pkg::ACT_READ: begin
                if (w_ridx_ok) begin
                    n_rword = css_pkg::PORT_W'(w_cells[w_ridx_sel]);
                end else begin
                    n_status = css_pkg::ST_RANGE;
                end
            end
            default: begin
                // unused action codes leave everything as is
                n_status = css_pkg::ST_OK;
            end
        endcase
    end

    // gap position stays below DEPTH whenever a shift is issued
    assign w_ctrl.en   = w_accept;
    assign w_ctrl.op   = w_gap;
    assign w_ctrl.pos  = w_gap_pos[css_pkg::IDX_W-1:0];
    assign w_ctrl.word = css_pkg::WORD_BITS'(i_word_in);

    // the row of cells, each linked to both neighbors
    for (genvar g = 0; g < css_pkg::DEPTH; g++) begin : g_cell
        logic [css_pkg::WORD_BITS-1:0] w_below;
        logic [css_pkg::WORD_BITS-1:0] w_above;

        if (g == 0) begin : g_first
            assign w_below = w_ctrl.word;
        end else begin : g_mid_lo
            assign w_below = w_cells[g-1];
        end

        if (g == css_pkg::DEPTH - 1) begin : g_last
            assign w_above = w_cells[g];
        end else begin : g_mid_hi
            assign w_above = w_cells[g+1];
        end

        css_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (css_pkg::IDX_W'(g)),
            .i_ctrl  (w_ctrl),
            .i_below (w_below),
            .i_above (w_above),
            .o_word  (w_cells[g])
        );
    end

    assign w_cur_sel = r_cursor[css_pkg::IDX_W-1:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_cursor     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count  <= n_count;
                r_cursor <= n_cursor;
            end
            if (w_accept) begin
                r_pend_valid <= 1'b1;
            end else if (w_pend_move) begin
                r_pend_valid <= 1'b0;
            end
            if (w_pend_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers; the row already holds the state left by the pending beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_status <= n_status;
            r_pend_rword  <= n_rword;
        end
        if (w_pend_move) begin
            r_out_status   <= r_pend_status;
            r_out_rword    <= r_pend_rword;
            r_out_has_cur  <= w_has_cur;
            r_out_cur_word <= w_has_cur ? css_pkg::PORT_W'(w_cells[w_cur_sel]) : '0;
            r_out_count    <= css_pkg::OUT_CNT_W'(r_count);
            r_out_cursor   <= css_pkg::OUT_CNT_W'(r_cursor);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_read_word    = r_out_rword;
    assign o_has_current  = r_out_has_cur;
    assign o_current_word = r_out_cur_word;
    assign o_word_count   = r_out_count;
    assign o_cursor_pos   = r_out_cursor;

`ifndef NO_ASSERTIONS
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_count)
        else $error("cursor beyond count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= css_pkg::CNT_W'(css_pkg::DEPTH))
        else $error("count beyond depth");

    a_current_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_has_current == (o_cursor_pos < o_word_count)))
        else $error("has_current disagrees with cursor and count");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && r_out_valid && !i_out_ready) |=> r_pend_valid)
        else $error("pending result lost while output stalled");
`endif

endmodule

/* src/css_cell.sv */
// css_cell: one word slot of the sequence row; shifts up or down with its
// neighbors or loads the new word; depends on css_pkg
module css_cell (
    input  logic                          i_clk,
    input  logic [css_pkg::IDX_W-1:0]     i_idx,
    input  css_pkg::t_cell_ctrl           i_ctrl,
    input  logic [css_pkg::WORD_BITS-1:0] i_below,
    input  logic [css_pkg::WORD_BITS-1:0] i_above,
    output logic [css_pkg::WORD_BITS-1:0] o_word
);

    logic [css_pkg::WORD_BITS-1:0] r_word;
    logic [css_pkg::WORD_BITS-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctrl.op)
            css_pkg::GAP_OPEN: begin
                // slots above the gap take the word below, the gap takes the new word
                if (i_idx > i_ctrl.pos) begin
                    n_word = i_below;
                end else if (i_idx == i_ctrl.pos) begin
                    n_word = i_ctrl.word;
                end
            end
            css_pkg::GAP_CLOSE: begin
                if (i_idx >= i_ctrl.pos) begin
                    n_word = i_above;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

/* bench/cursor_sequence_store_core_tb.sv */
`timescale 1ns / 100ps
// cursor_sequence_store_core_tb: self-checking bench for the cursor sequence store;
// directed list-edge beats, then random grow/shrink/mixed phases with random stalls
// depends on css_pkg and cursor_sequence_store_core
module cursor_sequence_store_core_tb;
    import css_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_BEATS = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_SHOWN    = 10;
    // action codes the block does not decode: no change, status ok
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 4'd10;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 4'd15;

    typedef enum logic [1:0] {
        PHASE_GROW   = 2'd0,
        PHASE_SHRINK = 2'd1,
        PHASE_MIXED  = 2'd2
    } t_phase;

    typedef struct {
        logic [ACT_W-1:0]  action;
        logic [PORT_W-1:0] word;
        logic [RIDX_W-1:0] ridx;
    } t_list_op;

    typedef struct {
        t_status              status;
        logic [PORT_W-1:0]    read_word;
        logic                 has_current;
        logic [PORT_W-1:0]    current_word;
        logic [OUT_CNT_W-1:0] word_count;
        logic [OUT_CNT_W-1:0] cursor_pos;
    } t_list_view;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [ACT_W-1:0]     i_action = '0;
    logic [PORT_W-1:0]    i_word_in = '0;
    logic [RIDX_W-1:0]    i_read_index = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [PORT_W-1:0]    o_read_word;
    logic                 o_has_current;
    logic [PORT_W-1:0]    o_current_word;
    logic [OUT_CNT_W-1:0] o_word_count;
    logic [OUT_CNT_W-1:0] o_cursor_pos;

    cursor_sequence_store_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_word_in      (i_word_in),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_read_word    (o_read_word),
        .o_has_current  (o_has_current),
        .o_current_word (o_current_word),
        .o_word_count   (o_word_count),
        .o_cursor_pos   (o_cursor_pos)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // beats waiting to be driven, and views the block still owes us
    t_list_op   pending_ops[$];
    t_list_view due_views[$];

    // shadow copy of the list: words, count, cursor
    logic [WORD_BITS-1:0] list_words [DEPTH];
    int list_count  = 0;
    int list_cursor = 0;

    int mismatches     = 0;
    int accepted_beats = 0;
    int results_seen   = 0;
    int total_ops      = 0;
    int cycle_count    = 0;
    int peak_count     = 0;
    int status_hits [4] = '{default: 0};

    // handshake seen at the last rising edge, used by the falling-edge drivers
    logic in_took  = 1'b0;
    logic out_took = 1'b0;
    int in_wait   = 0;
    int in_calm   = 0;
    int out_wait  = 0;
    int out_calm  = 0;
    t_list_op next_op;

    // make room at pos, shifting the upper words up one place
    function automatic void open_slot(int pos, logic [WORD_BITS-1:0] w);
        int i;
        for (i = list_count; i > pos; i--)
            list_words[i] = list_words[i-1];
        list_words[pos] = w;
        list_count++;
    endfunction

    // drop the word at pos, shifting the upper words down one place
    function automatic void close_slot(int pos);
        int i;
        for (i = pos; i + 1 < list_count; i++)
            list_words[i] = list_words[i+1];
        list_count--;
    endfunction

    // apply one action to the shadow list and return the view it should produce
    function automatic t_list_view apply_list_op(t_list_op op);
        t_list_view v;
        logic full;
        v.status    = ST_OK;
        v.read_word = '0;
        full = (list_count >= DEPTH);
        if (list_cursor > list_count)
            list_cursor = list_count;
        case (op.action)
            ACT_START: list_cursor = 0;
            ACT_ADVANCE: begin
                if (list_cursor < list_count) list_cursor++;
                else v.status = ST_RANGE;
            end
            ACT_END: list_cursor = list_count;
            ACT_INSERT: begin
                if (full) v.status = ST_FULL;
                else open_slot(list_cursor, op.word);
            end
            ACT_ATTACH: begin
                if (full) begin
                    v.status = ST_FULL;
                end else begin
                    if (list_cursor < list_count) list_cursor++;
                    open_slot(list_cursor, op.word);
                end
            end
            ACT_REMOVE: begin
                if (list_count == 0) begin
                    v.status = ST_EMPTY;
                end else if (list_cursor >= list_count) begin
                    // no current word: the tail goes, cursor tracks the count
                    list_count--;
                    list_cursor = list_count;
                end else begin
                    close_slot(list_cursor);
                end
            end
            ACT_RM_FRONT: begin
                if (list_count == 0) begin
                    v.status = ST_EMPTY;
                end else begin
                    list_cursor = 0;
                    close_slot(0);
                end
            end
            ACT_PUSH_FRONT: begin
                if (full) begin
                    v.status = ST_FULL;
                end else begin
                    list_cursor = 0;
                    open_slot(0, op.word);
                end
            end
            ACT_PUSH_END: begin
                if (full) begin
                    v.status = ST_FULL;
                end else begin
                    list_cursor = list_count;
                    open_slot(list_count, op.word);
                end
            end
            ACT_READ: begin
                if (op.ridx < list_count) v.read_word = list_words[op.ridx];
                else v.status = ST_RANGE;
            end
            default: ;
        endcase
        v.has_current  = (list_cursor < list_count);
        v.current_word = v.has_current ? list_words[list_cursor] : '0;
        v.word_count   = OUT_CNT_W'(list_count);
        v.cursor_pos   = OUT_CNT_W'(list_cursor);
        return v;
    endfunction

    // idle cycles before the next beat: zero in a calm stretch, else a uniform random draw
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function automatic void add_op(logic [ACT_W-1:0] action, logic [PORT_W-1:0] word,
                                   logic [RIDX_W-1:0] ridx);
        t_list_op op;
        op.action = action;
        op.word   = word;
        op.ridx   = ridx;
        pending_ops.push_back(op);
    endfunction

    // biased action choice so that phases fill the list to full or drain it to empty
    function automatic logic [ACT_W-1:0] pick_action(t_phase phase);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        if ((phase == PHASE_GROW && r < 85) || (phase == PHASE_MIXED && r < 40)) begin
            case ($urandom_range(0, 3))
                0: return ACT_INSERT;
                1: return ACT_ATTACH;
                2: return ACT_PUSH_FRONT;
                default: return ACT_PUSH_END;
            endcase
        end
        if ((phase == PHASE_SHRINK && r < 75) || (phase == PHASE_MIXED && r < 60))
            return ($urandom_range(0, 2) == 0) ? ACT_RM_FRONT : ACT_REMOVE;
        case ($urandom_range(0, 4))
            0: return ACT_START;
            1: return ACT_ADVANCE;
            2: return ACT_END;
            default: return ACT_READ;
        endcase
    endfunction

    function automatic logic [PORT_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // input driver: holds a beat until accepted, then waits its drawn gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && in_took)
                in_wait = draw_wait(in_calm);
            if (!i_in_valid || in_took) begin
                if (in_wait > 0) begin
                    in_wait--;
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    next_op = pending_ops.pop_front();
                    i_action     <= next_op.action;
                    i_word_in    <= next_op.word;
                    i_read_index <= next_op.ridx;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure: a drawn stall after each taken result beat
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (out_took)
                out_wait = draw_wait(out_calm);
            if (out_wait > 0) begin
                out_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // monitor: check result beats against the oldest view, predict accepted beats
    always @(posedge i_clk) begin
        t_list_op   op;
        t_list_view want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d views outstanding",
                     cycle_count, due_views.size());
            $display("Some tests failed");
            $finish;
        end else begin
            in_took  <= i_rst_n && i_in_valid && o_in_ready;
            out_took <= i_rst_n && o_out_valid && i_out_ready;
            if (i_rst_n && o_out_valid && i_out_ready) begin
                results_seen++;
                if (due_views.size() == 0) begin
                    flag_mismatch($sformatf("result beat with nothing expected (count %0d)",
                                            o_word_count));
                end else begin
                    want = due_views.pop_front();
                    if (o_status !== want.status || o_read_word !== want.read_word ||
                        o_has_current !== want.has_current ||
                        o_current_word !== want.current_word ||
                        o_word_count !== want.word_count ||
                        o_cursor_pos !== want.cursor_pos)
                        flag_mismatch($sformatf(
                            "result %0d exp st=%0d rd=%h hc=%b cw=%h n=%0d c=%0d / got st=%0d rd=%h hc=%b cw=%h n=%0d c=%0d",
                            results_seen, want.status, want.read_word, want.has_current,
                            want.current_word, want.word_count, want.cursor_pos,
                            o_status, o_read_word, o_has_current, o_current_word,
                            o_word_count, o_cursor_pos));
                end
            end
            if (i_rst_n && i_in_valid && o_in_ready) begin
                op.action = i_action;
                op.word   = i_word_in;
                op.ridx   = i_read_index;
                want = apply_list_op(op);
                status_hits[want.status]++;
                if (list_count > peak_count)
                    peak_count = list_count;
                due_views.push_back(want);
                accepted_beats++;
            end
        end
    end

    initial begin
        t_phase phase;
        int     span;
        int     n;
        int     k;

        // directed: empty-list errors, edges of word_in, every action and corner
        add_op(ACT_READ, '0, 5'd0);                  // read on empty list
        add_op(ACT_REMOVE, '0, '0);                  // remove on empty list
        add_op(ACT_RM_FRONT, '0, '0);
        add_op(ACT_ADVANCE, '0, '0);                 // advance with no current word
        add_op(ACT_START, '0, '0);
        add_op(ACT_END, '0, '0);
        add_op(ACT_SPARE_HI, '1, '1);                // undecoded action
        add_op(ACT_PUSH_END, '1, '0);
        add_op(ACT_PUSH_FRONT, '0, '0);
        add_op(ACT_INSERT, 32'hAAAA_AAAA, '0);       // insert at cursor 0
        add_op(ACT_ATTACH, 32'h5555_5555, '0);       // attach after current
        add_op(ACT_READ, '0, 5'd31);                 // read past the count
        add_op(ACT_READ, '0, 5'd3);
        add_op(ACT_ADVANCE, '0, '0);
        add_op(ACT_END, '0, '0);
        add_op(ACT_ADVANCE, '0, '0);                 // advance off the end
        add_op(ACT_INSERT, 32'h1234_5678, '0);       // insert with no current: append
        add_op(ACT_END, '0, '0);
        add_op(ACT_ATTACH, 32'h8000_0001, '0);       // attach with no current: append
        add_op(ACT_END, '0, '0);
        add_op(ACT_REMOVE, '0, '0);                  // remove with no current: drop tail
        add_op(ACT_START, '0, '0);
        add_op(ACT_REMOVE, '0, '0);                  // remove current, next slides in
        add_op(ACT_RM_FRONT, '0, '0);

        // random: first fill past full, then drain past empty, then mixed phases
        n = 0;
        while (n < RANDOM_BEATS) begin
            if (n == 0) begin
                phase = PHASE_GROW;
                span  = 70;
            end else if (n == 70) begin
                phase = PHASE_SHRINK;
                span  = 70;
            end else begin
                phase = t_phase'($urandom_range(0, 2));
                span  = $urandom_range(20, 70);
            end
            for (k = 0; k < span && n < RANDOM_BEATS; k++) begin
                add_op(pick_action(phase), pick_word(), RIDX_W'($urandom_range(0, 31)));
                n++;
            end
        end
        total_ops = pending_ops.size();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_beats < total_ops || due_views.size() != 0)
            @(posedge i_clk);
        // keep clocking so a stray extra result would still be caught
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d actions, %0d results checked, peak fill %0d of %0d",
                 accepted_beats, results_seen, peak_count, DEPTH);
        $display("statuses: ok %0d, full %0d, empty %0d, out of range %0d; mismatches %0d",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_RANGE], mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
src/css_pkg.sv
src/css_cell.sv
src/cursor_sequence_store_core.sv
bench/cursor_sequence_store_core_tb.sv
